// ===== design/urf_pkg.sv =====
`timescale 1ns / 1ps

package urf_pkg;

  // default parameter values
  localparam int unsigned CountWidthDef   = 20;
  localparam int unsigned TriggerTicksDef = 10;

  // field and register widths
  localparam int unsigned MaxDistW  = 10;
  localparam int unsigned TimeoutW  = 20;
  localparam int unsigned TempW     = 12;
  localparam int unsigned SpeedW    = 20;
  localparam int unsigned DistW     = 15;
  localparam int unsigned DividendW = 36;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned SDataW    = 8;
  localparam int unsigned MDataW    = 24;
  localparam int unsigned PcW       = 4;

  // speed of sound: (SpeedBase + SpeedSlope * t) >> 8, rounding folded into the base
  localparam logic [28:0]      SpeedBase  = 29'd142292395;
  localparam logic [14:0]      SpeedSlope = 15'd16267;
  localparam logic [DistW-1:0] DistSat    = 15'd20000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_DIST    = 2'd0,
    CFG_MAX_TIMEOUT = 2'd1,
    CFG_TEMPERATURE = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL_T,
    OP_SPEED,
    OP_DIV_STEP,
    OP_LAUNCH,
    OP_STEP,
    OP_MUL_FIN,
    OP_FINISH,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_BUSY,
    C_NO_START,
    C_DIV_RUN,
    C_NO_FIN,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic item;
    logic busy;
    logic start;
    logic div_run;
    logic fin;
    logic out_free;
  } status_t;

  // lowest bit first: trigger_level, busy_res, done_res, distance_q4, in_range
  typedef struct packed {
    logic             in_range;
    logic [DistW-1:0] distance_q4;
    logic             done_res;
    logic             busy_res;
    logic             trigger_level;
  } result_t;

  localparam logic [PcW-1:0] UpcWait = 4'd0;
  localparam logic [PcW-1:0] UpcDiv  = 4'd5;
  localparam logic [PcW-1:0] UpcStep = 4'd7;
  localparam logic [PcW-1:0] UpcEmit = 4'd10;

  // microprogram: do op, then jump to target if cond holds, else fall through
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_ACCEPT,   cond: C_NO_ITEM,  target: UpcWait};
      4'd1:    w = '{op: OP_NOP,      cond: C_BUSY,     target: UpcStep};
      4'd2:    w = '{op: OP_NOP,      cond: C_NO_START, target: UpcEmit};
      4'd3:    w = '{op: OP_MUL_T,    cond: C_NEVER,    target: UpcWait};
      4'd4:    w = '{op: OP_SPEED,    cond: C_NEVER,    target: UpcWait};
      4'd5:    w = '{op: OP_DIV_STEP, cond: C_DIV_RUN,  target: UpcDiv};
      4'd6:    w = '{op: OP_LAUNCH,   cond: C_ALWAYS,   target: UpcEmit};
      4'd7:    w = '{op: OP_STEP,     cond: C_NO_FIN,   target: UpcEmit};
      4'd8:    w = '{op: OP_MUL_FIN,  cond: C_NEVER,    target: UpcWait};
      4'd9:    w = '{op: OP_FINISH,   cond: C_NEVER,    target: UpcWait};
      4'd10:   w = '{op: OP_EMIT,     cond: C_OUT_FREE, target: UpcWait};
      4'd11:   w = '{op: OP_NOP,      cond: C_ALWAYS,   target: UpcEmit};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,   target: UpcWait};
    endcase
    return w;
  endfunction

endpackage

// ===== design/urf_sequencer.sv =====
`timescale 1ns / 1ps

module urf_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  urf_pkg::status_t status_i,
  output urf_pkg::uword_t  ctrl_o
);

  logic [urf_pkg::PcW-1:0] pc_q, pc_d;
  urf_pkg::uword_t         word;
  logic                    take;

  assign word   = urf_pkg::ucode(pc_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      urf_pkg::C_NEVER:    take = 1'b0;
      urf_pkg::C_ALWAYS:   take = 1'b1;
      urf_pkg::C_NO_ITEM:  take = !status_i.item;
      urf_pkg::C_BUSY:     take = status_i.busy;
      urf_pkg::C_NO_START: take = !status_i.start;
      urf_pkg::C_DIV_RUN:  take = status_i.div_run;
      urf_pkg::C_NO_FIN:   take = !status_i.fin;
      urf_pkg::C_OUT_FREE: take = status_i.out_free;
      default:             take = 1'b0;
    endcase
    pc_d = take ? word.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= urf_pkg::UpcWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== design/urf_divider.sv =====
`timescale 1ns / 1ps

module urf_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic                            step_i,
  input  logic [urf_pkg::DividendW-1:0]   dividend_i,
  input  logic [urf_pkg::SpeedW-1:0]      divisor_i,
  output logic [urf_pkg::DividendW-1:0]   quotient_o,
  output logic                            run_o
);

  localparam int unsigned DvW  = urf_pkg::DividendW;
  localparam int unsigned DsW  = urf_pkg::SpeedW;
  localparam int unsigned CntW = $clog2(DvW);

  logic [DvW-1:0]  quo_q, quo_d;
  logic [DsW-1:0]  rem_q, rem_d;
  logic [DsW-1:0]  dsr_q, dsr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DsW:0]    rem_sh;
  logic            fits;

  // one restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh = {rem_q, quo_q[DvW-1]};
    fits   = rem_sh >= {1'b0, dsr_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = CntW'(DvW - 1);
    end else if (step_i) begin
      rem_d = fits ? DsW'(rem_sh - {1'b0, dsr_q}) : rem_sh[DsW-1:0];
      quo_d = {quo_q[DvW-2:0], fits};
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = quo_q;
  assign run_o      = cnt_q != '0;

endmodule

// ===== design/urf_datapath.sv =====
`timescale 1ns / 1ps

module urf_datapath #(
  parameter int unsigned CountWidth   = urf_pkg::CountWidthDef,
  parameter int unsigned TriggerTicks = urf_pkg::TriggerTicksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urf_pkg::uword_t               ctrl_i,
  output urf_pkg::status_t              status_o,
  input  logic                          cfg_we_i,
  input  logic [urf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [urf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [urf_pkg::SDataW-1:0]    s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [urf_pkg::MDataW-1:0]    m_tdata
);

  localparam int unsigned MdW   = urf_pkg::MaxDistW;
  localparam int unsigned ToW   = urf_pkg::TimeoutW;
  localparam int unsigned TpW   = urf_pkg::TempW;
  localparam int unsigned SpW   = urf_pkg::SpeedW;
  localparam int unsigned DsW   = urf_pkg::DistW;
  localparam int unsigned DvW   = urf_pkg::DividendW;
  localparam int unsigned ProdW = CountWidth + SpW;
  localparam int unsigned ShW   = ProdW - 21;
  localparam int unsigned ResW  = $bits(urf_pkg::result_t);
  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam logic [CountWidth-1:0] TrigTicks = CountWidth'(TriggerTicks);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_LOW,
    PH_WAIT_RISE,
    PH_MEASURE
  } phase_e;

  // configuration
  logic [MdW-1:0]        max_dist_q, max_dist_d;
  logic [ToW-1:0]        max_to_q, max_to_d;
  logic signed [TpW-1:0] temp_q, temp_d;

  // measurement state
  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] tick_q, tick_d;
  logic [CountWidth-1:0] limit_q, limit_d;
  logic [SpW-1:0]        speed_q, speed_d;
  logic [CountWidth-1:0] dur_q, dur_d;
  logic [CountWidth-1:0] fin_dur_q, fin_dur_d;
  logic [DsW-1:0]        dist_q, dist_d;
  logic                  valid_q, valid_d;
  logic                  start_q, start_d;
  logic                  echo_q, echo_d;
  logic                  fin_q, fin_d;
  logic                  trig_q, trig_d;
  logic signed [27:0]    tmul_q, tmul_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic                  out_valid_q, out_valid_d;
  urf_pkg::result_t      out_q, out_d;

  logic [28:0]           num;
  logic [12:0]           dist5;
  logic [DvW-1:0]        dividend;
  logic [DvW-1:0]        quotient;
  logic [DvW-1:0]        tl_cap;
  logic                  div_run;
  logic                  out_free;
  logic                  ended;
  logic [CountWidth-1:0] tick_inc;
  logic [CountWidth-1:0] tick_sat;
  logic [ShW+DsW-1:0]    dist_wide;

  assign num      = urf_pkg::SpeedBase + {tmul_q[27], tmul_q};
  assign speed_d  = num[27:8];
  assign dist5    = {1'b0, max_dist_q, 2'b00} + {3'b000, max_dist_q};
  assign dividend = {dist5, 23'd0};
  assign out_free = !out_valid_q || m_tready;
  assign tick_inc = tick_q + 1'b1;
  assign tick_sat = (tick_q < CountMax) ? tick_inc : tick_q;
  assign dist_wide = {{DsW{1'b0}}, prod_q[ProdW-1:21]};

  urf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (ctrl_i.op == urf_pkg::OP_SPEED),
    .step_i     (ctrl_i.op == urf_pkg::OP_DIV_STEP),
    .dividend_i (dividend),
    .divisor_i  (speed_d),
    .quotient_o (quotient),
    .run_o      (div_run)
  );

  always_comb begin
    tl_cap = quotient;
    if (max_to_q != '0 && quotient > {{(DvW-ToW){1'b0}}, max_to_q}) begin
      tl_cap = {{(DvW-ToW){1'b0}}, max_to_q};
    end
    if (tl_cap > {{(DvW-CountWidth){1'b0}}, CountMax}) begin
      tl_cap = {{(DvW-CountWidth){1'b0}}, CountMax};
    end
  end

  always_comb begin
    max_dist_d  = max_dist_q;
    max_to_d    = max_to_q;
    temp_d      = temp_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    limit_d     = limit_q;
    dur_d       = dur_q;
    fin_dur_d   = fin_dur_q;
    dist_d      = dist_q;
    valid_d     = valid_q;
    start_d     = start_q;
    echo_d      = echo_q;
    fin_d       = fin_q;
    trig_d      = trig_q;
    tmul_d      = tmul_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !m_tready;
    out_d       = out_q;
    ended       = 1'b0;

    if (cfg_we_i) begin
      case (urf_pkg::cfg_idx_e'(cfg_idx_i))
        urf_pkg::CFG_MAX_DIST:    max_dist_d = cfg_wdata_i[MdW-1:0];
        urf_pkg::CFG_MAX_TIMEOUT: max_to_d   = cfg_wdata_i[ToW-1:0];
        urf_pkg::CFG_TEMPERATURE: temp_d     = $signed(cfg_wdata_i[TpW-1:0]);
        default: ;
      endcase
    end

    case (ctrl_i.op)
      urf_pkg::OP_ACCEPT: begin
        if (s_tvalid) begin
          start_d = s_tdata[0];
          echo_d  = s_tdata[1];
          fin_d   = 1'b0;
          trig_d  = 1'b0;
        end
      end
      urf_pkg::OP_MUL_T: begin
        tmul_d = $signed({13'd0, urf_pkg::SpeedSlope}) * $signed({{16{temp_q[TpW-1]}}, temp_q});
      end
      urf_pkg::OP_LAUNCH: begin
        limit_d = tl_cap[CountWidth-1:0];
        tick_d  = '0;
        dur_d   = '0;
        phase_d = PH_TRIG_LOW;
      end
      urf_pkg::OP_STEP: begin
        case (phase_q)
          PH_TRIG_LOW: begin
            tick_d  = '0;
            phase_d = PH_TRIG_HIGH;
          end
          PH_TRIG_HIGH: begin
            trig_d = 1'b1;
            if (tick_inc >= TrigTicks) begin
              tick_d  = '0;
              phase_d = PH_WAIT_LOW;
            end else begin
              tick_d = tick_inc;
            end
          end
          PH_WAIT_LOW, PH_WAIT_RISE, PH_MEASURE: begin
            tick_d = tick_sat;
            if (phase_q == PH_WAIT_LOW) begin
              if (!echo_q) begin
                phase_d = PH_WAIT_RISE;
              end
            end else if (phase_q == PH_WAIT_RISE) begin
              if (echo_q) begin
                dur_d   = CountWidth'(1);
                phase_d = PH_MEASURE;
              end
            end else if (echo_q) begin
              if (dur_q < CountMax) begin
                dur_d = dur_q + 1'b1;
              end
            end else begin
              // pulse ended: takes priority over the timeout
              ended     = 1'b1;
              fin_d     = 1'b1;
              fin_dur_d = dur_q;
            end
            if (!ended && tick_sat >= limit_q) begin
              fin_d     = 1'b1;
              fin_dur_d = '0;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      urf_pkg::OP_MUL_FIN: begin
        prod_d = {{SpW{1'b0}}, fin_dur_q} * {{CountWidth{1'b0}}, speed_q};
      end
      urf_pkg::OP_FINISH: begin
        dur_d   = fin_dur_q;
        dist_d  = (dist_wide > {{ShW{1'b0}}, urf_pkg::DistSat}) ? urf_pkg::DistSat
                                                              : dist_wide[DsW-1:0];
        valid_d = (fin_dur_q != '0) &&
                  ({{(MdW+25){1'b0}}, prod_q} <= {{ProdW{1'b0}}, max_dist_q, 25'd0});
        phase_d = PH_IDLE;
      end
      urf_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.trigger_level = trig_q;
          out_d.busy_res      = phase_q != PH_IDLE;
          out_d.done_res      = fin_q;
          out_d.distance_q4   = dist_q;
          out_d.in_range      = valid_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q  <= MdW'(400);
      max_to_q    <= '0;
      temp_q      <= TpW'(309);
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      limit_q     <= '0;
      speed_q     <= '0;
      dur_q       <= '0;
      fin_dur_q   <= '0;
      dist_q      <= '0;
      valid_q     <= 1'b0;
      start_q     <= 1'b0;
      echo_q      <= 1'b0;
      fin_q       <= 1'b0;
      trig_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      max_dist_q  <= max_dist_d;
      max_to_q    <= max_to_d;
      temp_q      <= temp_d;
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      limit_q     <= limit_d;
      if (ctrl_i.op == urf_pkg::OP_SPEED) begin
        speed_q <= speed_d;
      end
      dur_q       <= dur_d;
      fin_dur_q   <= fin_dur_d;
      dist_q      <= dist_d;
      valid_q     <= valid_d;
      start_q     <= start_d;
      echo_q      <= echo_d;
      fin_q       <= fin_d;
      trig_q      <= trig_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmul_q <= tmul_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign s_tready = ctrl_i.op == urf_pkg::OP_ACCEPT;
  assign m_tvalid = out_valid_q;
  assign m_tdata  = {{(urf_pkg::MDataW-ResW){1'b0}}, out_q};

  // the step word branches on the finish decided in the same cycle
  assign status_o = '{item:     s_tvalid,
                      busy:     phase_q != PH_IDLE,
                      start:    start_q,
                      div_run:  div_run,
                      fin:      fin_d,
                      out_free: out_free};

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done word still reports busy");

  a_trig_in_meas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.trigger_level |-> out_q.busy_res && !out_q.done_res)
    else $error("trigger driven outside a measurement");

  a_dist_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.distance_q4 <= urf_pkg::DistSat)
    else $error("distance above saturation value");

  a_trig_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TRIG_HIGH |-> tick_q < TrigTicks)
    else $error("trigger pulse counter overran");

endmodule

// ===== design/ultrasonic_range_finder_unit.sv =====
`timescale 1ns / 1ps

// Ultrasonic time-of-flight ranging controller. Each input word is one microsecond
// tick carrying a start request (bit 0) and the sampled echo level (bit 1); each
// tick produces exactly one result word with the trigger level, busy, done, the
// last distance in 1/16 cm and its in-range flag. A start in idle latches the speed
// of sound from the temperature register and an echo timeout, drives the trigger
// low for 2 ticks and high for TriggerTicks ticks, then times the echo pulse.
// Control runs from a microcoded sequencer over a small datapath, so the clocks a
// tick takes vary: an idle or in-progress tick is the shortest, the tick that
// finishes a measurement adds the product and range check, and the start tick adds
// the bit-serial divider computing the timeout. A result-side stall holds a tick in
// its emit step; the next tick is taken while a finished word waits.

module ultrasonic_range_finder_unit #(
  parameter int unsigned CountWidth   = urf_pkg::CountWidthDef,
  parameter int unsigned TriggerTicks = urf_pkg::TriggerTicksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [urf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [urf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // tick stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [urf_pkg::SDataW-1:0]    s_axis_tdata,  // [0] start_req, [1] echo_level
  // result stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] trigger_level, [1] busy_res, [2] done_res, [17:3] distance_q4, [18] in_range
  output logic [urf_pkg::MDataW-1:0]    m_axis_tdata
);

  urf_pkg::uword_t  ctrl;
  urf_pkg::status_t status;

  urf_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  urf_datapath #(
    .CountWidth   (CountWidth),
    .TriggerTicks (TriggerTicks)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata)
  );

endmodule

// ===== dv/ultrasonic_range_finder_unit_tb.sv =====
`timescale 1ns / 1ps

module ultrasonic_range_finder_unit_tb;

  localparam int unsigned     CntW       = urf_pkg::CountWidthDef;
  localparam int unsigned     CountMax   = (1 << urf_pkg::CountWidthDef) - 1;
  localparam longint unsigned CycleLimit = 64'd10_000_000;
  localparam int unsigned     TailCycles = 64;

  typedef enum logic [2:0] {
    RF_IDLE,
    RF_TRIG_LOW,
    RF_TRIG_HIGH,
    RF_ECHO_CLEAR,
    RF_ECHO_RISE,
    RF_ECHO_HIGH
  } rf_phase_e;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [urf_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [urf_pkg::CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [urf_pkg::SDataW-1:0]   s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [urf_pkg::MDataW-1:0]   m_axis_tdata;

  ultrasonic_range_finder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // register copies and ranging state of the predictor
  logic [urf_pkg::MaxDistW-1:0] cfg_max_cm  = 10'd400;
  logic [urf_pkg::TimeoutW-1:0] cfg_cap_us  = '0;
  logic [urf_pkg::TempW-1:0]    cfg_temp_q4 = 12'd309;
  rf_phase_e                    rf_phase    = RF_IDLE;
  logic [CntW-1:0]              rf_ticks    = '0;
  logic [CntW-1:0]              rf_limit    = '0;
  logic [urf_pkg::SpeedW-1:0]   rf_speed    = '0;
  logic [CntW-1:0]              rf_width    = '0;
  logic [urf_pkg::DistW-1:0]    rf_dist     = '0;
  logic                         rf_valid    = 1'b0;

  urf_pkg::result_t tick_results_q[$];
  bit               calm = 1'b0;
  int unsigned      fail_count;
  int unsigned      ticks_sent;
  int unsigned      results_seen;
  int unsigned      n_measured, n_timeout, n_in_range, n_saturated;
  longint unsigned  cycles = 0;

  // latch speed of sound and the echo timeout for a new measurement
  function automatic void arm_measurement();
    longint          t;
    longint          num;
    longint unsigned lim;
    t = $signed(cfg_temp_q4);
    num = 64'sd142292267 + 64'sd16267 * t + 64'sd128;
    if (num < 256) num = 256;
    rf_speed = num[27:8];
    if (rf_speed == '0) rf_speed = {{(urf_pkg::SpeedW-1){1'b0}}, 1'b1};
    lim = ((64'd5 * cfg_max_cm) << 23) / rf_speed;
    if (cfg_cap_us != '0 && lim > cfg_cap_us) lim = cfg_cap_us;
    if (lim > CountMax) lim = CountMax;
    rf_limit = lim[CntW-1:0];
  endfunction

  function automatic void close_measurement(input logic [CntW-1:0] width);
    longint unsigned prod;
    longint unsigned d;
    prod = 64'(width) * 64'(rf_speed);
    d = prod >> 21;
    rf_width = width;
    rf_dist = (d > 64'(urf_pkg::DistSat)) ? urf_pkg::DistSat : d[urf_pkg::DistW-1:0];
    rf_valid = (width != '0) && (prod <= (64'(cfg_max_cm) << 25));
    rf_phase = RF_IDLE;
    n_measured++;
    if (rf_valid) n_in_range++;
    if (d > 64'(urf_pkg::DistSat)) n_saturated++;
  endfunction

  function automatic urf_pkg::result_t predict_tick(input logic start, input logic echo);
    urf_pkg::result_t r;
    logic             ended;
    r = '0;
    ended = 1'b0;
    case (rf_phase)
      RF_IDLE: begin
        if (start) begin
          arm_measurement();
          rf_ticks = '0;
          rf_width = '0;
          rf_phase = RF_TRIG_LOW;
        end
      end
      RF_TRIG_LOW: begin
        rf_ticks = '0;
        rf_phase = RF_TRIG_HIGH;
      end
      RF_TRIG_HIGH: begin
        r.trigger_level = 1'b1;
        rf_ticks++;
        if (rf_ticks >= urf_pkg::TriggerTicksDef) begin
          rf_ticks = '0;
          rf_phase = RF_ECHO_CLEAR;
        end
      end
      default: begin
        if (rf_ticks < CountMax) rf_ticks++;
        if (rf_phase == RF_ECHO_CLEAR) begin
          if (!echo) rf_phase = RF_ECHO_RISE;
        end else if (rf_phase == RF_ECHO_RISE) begin
          if (echo) begin
            rf_width = {{(CntW-1){1'b0}}, 1'b1};
            rf_phase = RF_ECHO_HIGH;
          end
        end else if (echo) begin
          if (rf_width < CountMax) rf_width++;
        end else begin
          close_measurement(rf_width);
          ended = 1'b1;
          r.done_res = 1'b1;
        end
        // a pulse that ends on the timeout tick wins
        if (!ended && rf_ticks >= rf_limit) begin
          close_measurement('0);
          r.done_res = 1'b1;
          n_timeout++;
        end
      end
    endcase
    r.busy_res    = (rf_phase != RF_IDLE);
    r.distance_q4 = rf_dist;
    r.in_range    = rf_valid;
    return r;
  endfunction

  task automatic check_result(input urf_pkg::result_t got);
    urf_pkg::result_t want;
    logic             bad;
    results_seen++;
    if (tick_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("result word %0d arrived with nothing pending: %h",
                                     results_seen, got);
      return;
    end
    want = tick_results_q.pop_front();
    bad = (got.trigger_level !== want.trigger_level) || (got.busy_res !== want.busy_res) ||
          (got.done_res !== want.done_res) || (got.distance_q4 !== want.distance_q4) ||
          (got.in_range !== want.in_range);
    if (bad) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"word %0d: want trig %0b busy %0b done %0b dist %0d rng %0b, ",
                  "got %0b %0b %0b %0d %0b"},
                 results_seen, want.trigger_level, want.busy_res, want.done_res,
                 want.distance_q4, want.in_range, got.trigger_level, got.busy_res,
                 got.done_res, got.distance_q4, got.in_range);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      check_result(m_axis_tdata[$bits(urf_pkg::result_t)-1:0]);
  end

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 19);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ultrasonic_range_finder_unit_tb: done, errors");
      $finish;
    end
  end

  // one microsecond tick; tvalid stays high on return
  task automatic send_tick(input logic start, input logic echo);
    if (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 19) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(urf_pkg::SDataW-2){1'b0}}, echo, start};
    do @(posedge clk_i); while (!s_axis_tready);
    tick_results_q.push_back(predict_tick(start, echo));
    ticks_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_ranging(input int unsigned max_cm, input int unsigned cap_us,
                                 input int temp_q4);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= urf_pkg::CFG_MAX_DIST;
    cfg_wdata_i <= max_cm[urf_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    cfg_idx_i   <= urf_pkg::CFG_MAX_TIMEOUT;
    cfg_wdata_i <= cap_us[urf_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    cfg_idx_i   <= urf_pkg::CFG_TEMPERATURE;
    cfg_wdata_i <= temp_q4[urf_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_max_cm  = max_cm[urf_pkg::MaxDistW-1:0];
    cfg_cap_us  = cap_us[urf_pkg::TimeoutW-1:0];
    cfg_temp_q4 = temp_q4[urf_pkg::TempW-1:0];
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'($urandom_range(1)));
  endtask

  // echo after the trigger: lingering high, low gap, pulse, then low;
  // optionally reprogram at a given watched tick
  task automatic measure(input int lead_high, input int gap_low, input int pulse,
                         input bit noisy, input int reprog_at);
    int   watched;
    logic echo;
    logic watching;
    watched = 0;
    send_tick(1'b1, 1'($urandom_range(1)));
    while (rf_phase != RF_IDLE) begin
      watching = (rf_phase == RF_ECHO_CLEAR) || (rf_phase == RF_ECHO_RISE) ||
                 (rf_phase == RF_ECHO_HIGH);
      if (watching) begin
        if (watched == reprog_at)
          program_ranging($urandom_range(1, 1000), $urandom_range(8, 200),
                          int'($urandom_range(0, 1920)) - 640);
        if (noisy) echo = 1'($urandom_range(1));
        else echo = (watched < lead_high) ||
                    (watched >= lead_high + gap_low && watched < lead_high + gap_low + pulse);
        watched++;
      end else begin
        echo = 1'($urandom_range(1));
      end
      // start is ignored while busy, the done tick included
      send_tick(1'($urandom_range(1)), echo);
    end
  endtask

  task automatic test_idle_ticks();
    idle_ticks(4);
  endtask

  task automatic test_default_setting();
    measure(0, 3, 30, 1'b0, -1);
  endtask

  task automatic test_timeout_edge();
    program_ranging(400, 30, 309);
    measure(0, 4, 25, 1'b0, -1);
    measure(0, 4, 26, 1'b0, -1);
    measure(0, 0, 10, 1'b0, -1);
    measure(4, 2, 15, 1'b0, -1);
  endtask

  task automatic test_zero_range();
    program_ranging(0, 0, 309);
    measure(0, 0, 5, 1'b0, -1);
    measure(2, 1, 5, 1'b0, -1);
  endtask

  task automatic test_range_limit();
    // just inside and just past one centimetre
    program_ranging(1, 0, 309);
    measure(0, 2, 58, 1'b0, -1);
    measure(0, 2, 59, 1'b0, -1);
  endtask

  task automatic test_temperature_extremes();
    program_ranging(1023, 300, -2048);
    measure(1, 3, 40, 1'b0, -1);
    program_ranging(1023, 300, 2047);
    measure(0, 2, 30, 1'b0, -1);
    program_ranging(1000, 300, -640);
    measure(0, 1, 20, 1'b0, -1);
    program_ranging(1000, 300, 1280);
    measure(0, 1, 20, 1'b0, -1);
    program_ranging(1000, 1048575, -1);
    measure(0, 1, 20, 1'b0, -1);
    program_ranging(512, 300, 0);
    measure(0, 3, 10, 1'b0, -1);
  endtask

  task automatic test_reconfig_mid_measure();
    program_ranging(600, 200, 309);
    measure(2, 3, 40, 1'b0, 20);
    measure(0, 2, 30, 1'b0, 3);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned n;
    int unsigned max_cm;
    int unsigned cap_us;
    int          temp_q4;
    first = ticks_sent;
    n = 0;
    while (ticks_sent < first + 300) begin
      if (n % 4 == 0) begin
        max_cm = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 1023 : 0)
                                          : $urandom_range(1, 1000);
        cap_us = $urandom_range(4, 120);
        // uncapped only with a short range so the timeout stays small
        if ($urandom_range(7) == 0) begin
          cap_us = 0;
          max_cm = $urandom_range(0, 2);
        end
        if ($urandom_range(7) == 0) temp_q4 = int'($urandom_range(0, 4095)) - 2048;
        else temp_q4 = int'($urandom_range(0, 1920)) - 640;
        program_ranging(max_cm, cap_us, temp_q4);
      end
      calm = (n >= 2 && n < 6);
      idle_ticks($urandom_range(0, 3));
      measure(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0, $urandom_range(0, 8),
              ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40),
              $urandom_range(5) == 0, ($urandom_range(11) == 0) ? $urandom_range(0, 20) : -1);
      if ($urandom_range(9) == 0) drain_results();
      n++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_default_setting();
    test_timeout_edge();
    test_zero_range();
    test_range_limit();
    test_temperature_extremes();
    test_reconfig_mid_measure();
    test_random_traffic();

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    fail_count += tick_results_q.size();

    $display("ticks %0d, result words %0d, measurements %0d (timeouts %0d, in range %0d)",
             ticks_sent, results_seen, n_measured, n_timeout, n_in_range);
    $display("saturated distances %0d, temperatures down to -128 C and up to 128 C", n_saturated);
    if (fail_count == 0) $display("ultrasonic_range_finder_unit_tb: done, clean");
    else $display("ultrasonic_range_finder_unit_tb: done, errors");
    $finish;
  end

endmodule
